>>> design/rcfd_pkg.sv
// rcfd_pkg: shared types, constants and helpers for the remote-control frame decoder
// used by rcfd_front, rcfd_queue, rcfd_back and the top level
package rcfd_pkg;

  // frame geometry
  localparam int FRAME_BYTES_DEF = 18;

  // configuration register indexes (paddr[2])
  localparam logic REG_SPEED_LIMIT    = 1'b0;
  localparam logic REG_MOUSE_YAW_GAIN = 1'b1;

  // configuration reset values
  localparam logic [10:0] SPEED_LIMIT_RESET = 11'd800;
  localparam logic [15:0] YAW_GAIN_RESET    = 16'd256;

  // switch codes
  localparam logic [1:0] SW_INVALID = 2'd0;
  localparam logic [1:0] SW_UP      = 2'd1;
  localparam logic [1:0] SW_MID     = 2'd2;
  localparam logic [1:0] SW_DOWN    = 2'd3;

  // ramp constants
  localparam logic signed [13:0] RAMP_STEP   = 14'sd10;
  localparam logic signed [13:0] TURN_DECAY  = 14'sd20;
  localparam logic [23:0]        MOUSE_CLAMP = 24'd350;

  // floor(v / 10) = (v * DIV10_MUL) >> DIV10_SHIFT, exact for v below 43699
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  // key bit positions
  localparam int KEY_W = 0;
  localparam int KEY_S = 1;
  localparam int KEY_A = 2;
  localparam int KEY_D = 3;
  localparam int KEY_Q = 6;
  localparam int KEY_E = 7;

  // decoded frame handed from front to back
  typedef struct packed {
    logic [10:0] ch0;
    logic [10:0] ch1;
    logic [10:0] ch2;
    logic [10:0] ch3;
    logic [1:0]  sw_left;
    logic [1:0]  sw_right;
    logic [15:0] mouse_x;
    logic [15:0] keys;
  } frame_rec_t;

  // configuration handed to the back end
  typedef struct packed {
    logic [10:0] speed_limit;
    logic [15:0] mouse_yaw_gain;
  } cfg_t;

  // symmetric clamp to [-lim, lim]
  function automatic logic signed [13:0] clamp_sym(logic signed [13:0] v,
                                                   logic signed [13:0] lim);
    logic signed [13:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> design/rc_frame_decoder_key_ramp.sv
// rc_frame_decoder_key_ramp: top level, configuration registers and block wiring
// depends on rcfd_pkg, rcfd_front, rcfd_queue, rcfd_back
//
// Decodes a remote-control receiver frame taken one byte per cycle while not stalled
// and gives one result per completed frame: stick channels, switches, keys and three
// ramped motion commands. The byte input takes one transfer every cycle while
// item_stall is low; frame_start forces byte 0 and a frame also completes on its own
// after FRAME_BYTES bytes. The back end first computes the reception toggle, fault
// check and the mouse-gain product into registers, then applies the ramps and loads the
// result register; it takes no new frame until the last one is loaded. A two-entry
// frame queue sits between the byte assembler and the back end, so the byte input
// stalls only once two completed frames wait behind a stalled result.
// Configuration registers are at byte address 0 (speed_limit) and 4 (mouse_yaw_gain).
module rc_frame_decoder_key_ramp import rcfd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // byte input
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  // result output
  output logic               result_valid,
  input  logic               result_stall,
  output logic [10:0]        stick_ch0,
  output logic [10:0]        stick_ch1,
  output logic [10:0]        stick_ch2,
  output logic [10:0]        stick_ch3,
  output logic [1:0]         left_sw,
  output logic [1:0]         right_sw,
  output logic [15:0]        key_bits,
  output logic signed [11:0] forward_cmd,
  output logic signed [11:0] strafe_cmd,
  output logic signed [11:0] turn_cmd,
  output logic               frame_fault,
  output logic               rx_enabled
);

  cfg_t       cfg;
  logic       cfg_write;
  logic       accept;
  logic       push;
  logic       pop;
  logic       q_empty;
  logic       q_full;
  frame_rec_t push_rec;
  frame_rec_t head;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_limit    <= SPEED_LIMIT_RESET;
      cfg.mouse_yaw_gain <= YAW_GAIN_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_SPEED_LIMIT:    cfg.speed_limit    <= pwdata[10:0];
        REG_MOUSE_YAW_GAIN: cfg.mouse_yaw_gain <= pwdata[15:0];
        default:            cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SPEED_LIMIT:    prdata = {21'd0, cfg.speed_limit};
      REG_MOUSE_YAW_GAIN: prdata = {16'd0, cfg.mouse_yaw_gain};
      default:            prdata = '0;
    endcase
  end

  // byte input handshake
  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;

  rcfd_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .push        (push),
    .push_rec    (push_rec)
  );

  rcfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rcfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .empty        (q_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stick_ch0    (stick_ch0),
    .stick_ch1    (stick_ch1),
    .stick_ch2    (stick_ch2),
    .stick_ch3    (stick_ch3),
    .left_sw      (left_sw),
    .right_sw     (right_sw),
    .key_bits     (key_bits),
    .forward_cmd  (forward_cmd),
    .strafe_cmd   (strafe_cmd),
    .turn_cmd     (turn_cmd),
    .frame_fault  (frame_fault),
    .rx_enabled   (rx_enabled)
  );

endmodule

>>> design/rcfd_front.sv
// rcfd_front: byte assembler, tracks byte position and decodes a completed frame
// depends on rcfd_pkg (frame_rec_t)
module rcfd_front import rcfd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  output logic       push,
  output frame_rec_t push_rec
);

  localparam int PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] LAST_POS = PosW'(FRAME_BYTES - 1);

  logic [PosW-1:0] pos;
  logic [PosW-1:0] pos_eff;
  logic            last;

  // kept bytes: 0..7 hold sticks, switches and mouse, 14..15 hold keys
  logic [7:0] lo_bytes [8];
  logic [7:0] key_bytes [2];
  logic [7:0] b [8];
  logic [7:0] k [2];

  assign pos_eff = frame_start ? '0 : pos;
  assign last    = (pos_eff == LAST_POS);
  assign push    = accept && last;

  // byte position, wraps after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= last ? '0 : pos_eff + 1'b1;
    end
  end

  // store the bytes that carry decoded fields
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 8; i++) begin
        if (pos_eff == PosW'(i)) lo_bytes[i] <= rx_byte;
      end
      for (int i = 0; i < 2; i++) begin
        if (pos_eff == PosW'(14 + i)) key_bytes[i] <= rx_byte;
      end
    end
  end

  // current byte overrides its stored slot on the completing transfer
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = (pos_eff == PosW'(i)) ? rx_byte : lo_bytes[i];
    end
    for (int i = 0; i < 2; i++) begin
      k[i] = (pos_eff == PosW'(14 + i)) ? rx_byte : key_bytes[i];
    end
  end

  // field decode
  always_comb begin
    push_rec.ch0      = {b[1][2:0], b[0]};
    push_rec.ch1      = {b[2][5:0], b[1][7:3]};
    push_rec.ch2      = {b[4][0], b[3], b[2][7:6]};
    push_rec.ch3      = {b[5][3:0], b[4][7:1]};
    push_rec.sw_right = b[5][5:4];
    push_rec.sw_left  = b[5][7:6];
    push_rec.mouse_x  = {b[7], b[6]};
    push_rec.keys     = {k[1], k[0]};
  end

endmodule

>>> design/rcfd_queue.sv
// rcfd_queue: two-entry queue of decoded frames between front and back
// depends on rcfd_pkg (frame_rec_t)
module rcfd_queue import rcfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t push_rec,
  input  logic       pop,
  output frame_rec_t head,
  output logic       empty,
  output logic       full
);

  frame_rec_t  entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_rec;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/rcfd_back.sv
// rcfd_back: reception toggle, fault check, held values, motion ramps and result register
// depends on rcfd_pkg (frame_rec_t, cfg_t, constants, clamp_sym)
module rcfd_back import rcfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  frame_rec_t         head,
  input  logic               empty,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [10:0]        stick_ch0,
  output logic [10:0]        stick_ch1,
  output logic [10:0]        stick_ch2,
  output logic [10:0]        stick_ch3,
  output logic [1:0]         left_sw,
  output logic [1:0]         right_sw,
  output logic [15:0]        key_bits,
  output logic signed [11:0] forward_cmd,
  output logic signed [11:0] strafe_cmd,
  output logic signed [11:0] turn_cmd,
  output logic               frame_fault,
  output logic               rx_enabled
);

  // held state
  logic [1:0]  prev_sw;
  logic        enable_flag;
  logic [10:0] held_ch [4];
  logic [1:0]  held_sl;
  logic [1:0]  held_sr;
  logic [15:0] held_keys;
  logic [15:0] held_mouse;
  logic signed [11:0] fwd_ramp;
  logic signed [11:0] str_ramp;
  logic signed [11:0] trn_ramp;

  // first step registers
  logic        calc;
  logic        fault_q;
  logic [31:0] prod_q;
  logic        mouse_neg_q;
  logic [10:0] lim7_q;
  logic [10:0] lim8_q;

  // first step: toggle and fault
  logic        en;
  logic        fault;
  logic [15:0] mouse_sel;
  logic [15:0] mouse_mag;
  logic [13:0] lim_x7;
  logic [13:0] lim_x8;
  logic [29:0] div7;
  logic [29:0] div8;

  assign pop = calc ? 1'b0 : !empty;

  always_comb begin
    en = enable_flag ^ ((head.sw_right == SW_DOWN) && (prev_sw == SW_UP));
    fault = en && ((head.sw_right == SW_INVALID) || (head.sw_left == SW_INVALID));
    mouse_sel = (en && !fault) ? head.mouse_x : held_mouse;
    mouse_mag = mouse_sel[15] ? 16'(-mouse_sel) : mouse_sel;
    lim_x8 = {cfg.speed_limit, 3'b000};
    lim_x7 = lim_x8 - {3'b000, cfg.speed_limit};
    div7 = {16'd0, lim_x7} * {14'd0, DIV10_MUL};
    div8 = {16'd0, lim_x8} * {14'd0, DIV10_MUL};
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fault_q     <= fault;
      prod_q      <= {16'd0, mouse_mag} * {16'd0, cfg.mouse_yaw_gain};
      mouse_neg_q <= mouse_sel[15];
      lim7_q      <= div7[DIV10_SHIFT +: 11];
      lim8_q      <= div8[DIV10_SHIFT +: 11];
    end
  end

  // held values, updated only by a frame that passes the check
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sw     <= SW_DOWN;
      enable_flag <= 1'b1;
      for (int i = 0; i < 4; i++) held_ch[i] <= '0;
      held_sl     <= '0;
      held_sr     <= '0;
      held_keys   <= '0;
      held_mouse  <= '0;
    end else if (pop && !fault) begin
      enable_flag <= en;
      prev_sw     <= head.sw_right;
      if (en) begin
        held_ch[0] <= head.ch0;
        held_ch[1] <= head.ch1;
        held_ch[2] <= head.ch2;
        held_ch[3] <= head.ch3;
        held_sl    <= head.sw_left;
        held_sr    <= head.sw_right;
        held_keys  <= head.keys;
        held_mouse <= head.mouse_x;
      end
    end
  end

  // second step: ramps
  logic        out_free;
  logic        load;
  logic [8:0]  mterm_mag;
  logic signed [13:0] mterm;
  logic signed [13:0] lim_s;
  logic signed [13:0] lim7_s;
  logic signed [13:0] lim8_s;
  logic signed [13:0] fwd_next;
  logic signed [13:0] str_next;
  logic signed [13:0] trn_sum;
  logic signed [13:0] trn_step;
  logic signed [13:0] trn_next;
  logic kw, ks, ka, kd, kq, ke;

  assign out_free = !result_valid || !result_stall;
  assign load     = calc && out_free;

  always_comb begin
    kw = held_keys[KEY_W];
    ks = held_keys[KEY_S];
    ka = held_keys[KEY_A];
    kd = held_keys[KEY_D];
    kq = held_keys[KEY_Q];
    ke = held_keys[KEY_E];
    lim_s  = signed'({3'b000, cfg.speed_limit});
    lim7_s = signed'({3'b000, lim7_q});
    lim8_s = signed'({3'b000, lim8_q});

    // forward and strafe step then clamp, clear when not pressed one way
    if (kw ^ ks) begin
      fwd_next = clamp_sym({{2{fwd_ramp[11]}}, fwd_ramp} + (kw ? RAMP_STEP : -RAMP_STEP), lim_s);
    end else begin
      fwd_next = '0;
    end
    if (ka ^ kd) begin
      str_next = clamp_sym({{2{str_ramp[11]}}, str_ramp} + (kd ? RAMP_STEP : -RAMP_STEP),
                           lim7_s);
    end else begin
      str_next = '0;
    end

    // mouse term, magnitude clamped, sign opposite to mouse x
    mterm_mag = (prod_q[31:8] > MOUSE_CLAMP) ? MOUSE_CLAMP[8:0] : prod_q[16:8];
    mterm = mouse_neg_q ? signed'({5'd0, mterm_mag}) : -signed'({5'd0, mterm_mag});
    trn_sum = {{2{trn_ramp[11]}}, trn_ramp} + mterm;

    // q/e step, reversed with s; otherwise decay toward zero
    trn_step = (kq ^ ks) ? RAMP_STEP : -RAMP_STEP;
    priority if (kq ^ ke) begin
      trn_next = trn_sum + trn_step;
    end else if (trn_sum > 14'sd0) begin
      trn_next = (trn_sum > TURN_DECAY) ? trn_sum - TURN_DECAY : '0;
    end else if (trn_sum < 14'sd0) begin
      trn_next = (trn_sum < -TURN_DECAY) ? trn_sum + TURN_DECAY : '0;
    end else begin
      trn_next = trn_sum;
    end
    trn_next = clamp_sym(trn_next, lim8_s);
  end

  // step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      calc <= 1'b0;
    end else if (pop) begin
      calc <= 1'b1;
    end else if (load) begin
      calc <= 1'b0;
    end
  end

  // ramp state, frozen on a dropped frame
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_ramp <= '0;
      str_ramp <= '0;
      trn_ramp <= '0;
    end else if (load && !fault_q) begin
      fwd_ramp <= fwd_next[11:0];
      str_ramp <= str_next[11:0];
      trn_ramp <= trn_next[11:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stick_ch0    <= held_ch[0];
      stick_ch1    <= held_ch[1];
      stick_ch2    <= held_ch[2];
      stick_ch3    <= held_ch[3];
      left_sw      <= held_sl;
      right_sw     <= held_sr;
      key_bits     <= held_keys;
      forward_cmd  <= fault_q ? fwd_ramp : fwd_next[11:0];
      strafe_cmd   <= fault_q ? str_ramp : str_next[11:0];
      turn_cmd     <= fault_q ? trn_ramp : trn_next[11:0];
      frame_fault  <= fault_q;
      rx_enabled   <= enable_flag;
    end
  end

endmodule
